// ----- src/hjm_pkg.sv -----
// ----------------------------------------------------------------------------
// hjm_pkg: shared types and constants of the joypad register core
// Operation codes, select codes, configuration indexes and the item, result
// and configuration structs used between the modules.
// ----------------------------------------------------------------------------
package hjm_pkg;

  // Default number of players wired to the core.
  localparam int PLAYERS_DEF = 4;
  // Keys per player: four directions then four buttons.
  localparam int KEYS        = 8;
  localparam int LINES       = 4;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  // All lines released.
  localparam logic [LINES-1:0] LINES_IDLE = 4'hF;
  // Register bits 7:6 always read as one.
  localparam logic [1:0]       JOYP_TOP   = 2'b11;

  // Select codes written to register bits 5:4.
  localparam logic [1:0] SEL_BOTH    = 2'd0;
  localparam logic [1:0] SEL_BUTTONS = 2'd1;
  localparam logic [1:0] SEL_DIRS    = 2'd2;
  localparam logic [1:0] SEL_ID      = 2'd3;

  // Direction line positions.
  localparam int LINE_RIGHT = 0;
  localparam int LINE_LEFT  = 1;
  localparam int LINE_UP    = 2;
  localparam int LINE_DOWN  = 3;

  typedef enum logic [2:0] {
    OP_WR_SEL   = 3'd0,
    OP_SET_KEY  = 3'd1,
    OP_SET_MASK = 3'd2,
    OP_PASS     = 3'd3,
    OP_ACK_IRQ  = 3'd4,
    OP_CLR_ACC  = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPD_DIS = 2'd0,
    CFG_SGB     = 2'd1,
    CFG_PCOUNT  = 2'd2,
    CFG_OPPOSE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       upd_dis;
    logic       sgb;
    logic [2:0] pcount;
    logic       oppose;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       sel;
    logic [1:0]       player;
    logic [2:0]       key_index;
    logic             pressed;
    logic [KEYS-1:0]  key_mask;
    logic             clear_all;
    logic [LINES-1:0] nibble;
    logic [1:0]       active_player;
  } item_t;

  typedef struct packed {
    logic [7:0] joyp_value;
    logic       irq;
    logic       accessed;
  } res_t;

endpackage

// ----- src/hjm_in_reg.sv -----
// ----------------------------------------------------------------------------
// hjm_in_reg: input register
// Unpacks an accepted transfer into an item and holds it until the state
// update stage takes it.
// ----------------------------------------------------------------------------
module hjm_in_reg
  import hjm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  input  logic                 advance,
  output logic                 item_vld,
  output item_t                item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  // A new item may enter when none is held or the held one leaves in the same cycle.
  assign in_tready = !vld_r || advance;
  assign accept    = in_tvalid && in_tready;

  // Field unpacking, lowest bits first.
  always_comb begin
    item_nxt.op            = op_t'(in_tuser[2:0]);
    item_nxt.sel           = in_tdata[1:0];
    item_nxt.player        = in_tdata[3:2];
    item_nxt.key_index     = in_tdata[6:4];
    item_nxt.pressed       = in_tdata[7];
    item_nxt.key_mask      = in_tdata[15:8];
    item_nxt.clear_all     = in_tdata[16];
    item_nxt.nibble        = in_tdata[20:17];
    item_nxt.active_player = in_tdata[22:21];
  end

  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ----- src/hjm_engine.sv -----
// ----------------------------------------------------------------------------
// hjm_engine: joypad state and single-pass update
// Holds the key matrix, select bits, line bits and interrupt flags, and
// applies one item per cycle while fire is high to produce the next state and the read value.
// ----------------------------------------------------------------------------
module hjm_engine
  import hjm_pkg::*;
#(
  parameter int PLAYERS = PLAYERS_DEF
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  logic [KEYS-1:0]  mtx_r   [PLAYERS];
  logic [KEYS-1:0]  mtx_nxt [PLAYERS];
  logic [1:0]       sel_r;
  logic [1:0]       sel_nxt;
  logic [LINES-1:0] line_r;
  logic [LINES-1:0] line_nxt;
  logic             irq_r;
  logic             irq_nxt;
  logic             acc_r;
  logic             acc_nxt;

  logic [1:0]       who;
  logic [KEYS-1:0]  keys;
  logic [LINES-1:0] dirs_n;
  logic [LINES-1:0] calc;
  logic             recalc;
  logic             raise;

  // Key matrix and select bits after the item.
  always_comb begin
    sel_nxt = sel_r;
    for (int i = 0; i < PLAYERS; i++) begin
      mtx_nxt[i] = mtx_r[i];
    end
    case (item.op)
      OP_WR_SEL: begin
        sel_nxt = item.sel;
      end
      OP_SET_KEY: begin
        for (int i = 0; i < PLAYERS; i++) begin
          if (item.player == 2'(i)) begin
            mtx_nxt[i][item.key_index] = item.pressed;
          end
        end
      end
      OP_SET_MASK: begin
        for (int i = 0; i < PLAYERS; i++) begin
          if (item.player == 2'(i)) begin
            mtx_nxt[i] = item.key_mask;
          end else if (item.clear_all) begin
            mtx_nxt[i] = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Keys of the player being read; absent players read as released.
  always_comb begin
    who  = cfg.sgb ? item.active_player : 2'd0;
    keys = '0;
    for (int i = 0; i < PLAYERS; i++) begin
      if (who == 2'(i)) begin
        keys = mtx_nxt[i];
      end
    end
  end

  // Line value for the selected key group.
  always_comb begin
    dirs_n = ~keys[LINES-1:0];
    if (!cfg.oppose) begin
      if (!dirs_n[LINE_RIGHT]) begin
        dirs_n[LINE_LEFT] = 1'b1;
      end
      if (!dirs_n[LINE_UP]) begin
        dirs_n[LINE_DOWN] = 1'b1;
      end
    end
    case (sel_nxt)
      SEL_ID: begin
        if (cfg.sgb && (cfg.pcount > 3'd1)) begin
          calc = LINES_IDLE - {2'b00, who};
        end else begin
          calc = LINES_IDLE;
        end
      end
      SEL_DIRS:    calc = dirs_n;
      SEL_BUTTONS: calc = ~keys[KEYS-1:LINES];
      default:     calc = ~(keys[LINES-1:0] | keys[KEYS-1:LINES]);
    endcase
  end

  // Line bits and interrupt flags after the item.
  always_comb begin
    line_nxt = line_r;
    irq_nxt  = irq_r;
    acc_nxt  = acc_r;
    raise    = 1'b0;
    recalc   = (item.op == OP_WR_SEL) || (item.op == OP_SET_KEY) ||
               (item.op == OP_SET_MASK);
    if (recalc && !cfg.upd_dis) begin
      line_nxt = calc;
      raise    = (calc != line_r);
    end
    case (item.op)
      OP_PASS: begin
        line_nxt = item.nibble;
        raise    = |(line_r & ~item.nibble);
      end
      OP_ACK_IRQ: irq_nxt = 1'b0;
      OP_CLR_ACC: acc_nxt = 1'b0;
      default: begin
      end
    endcase
    if (raise && !irq_r) begin
      irq_nxt = 1'b1;
      acc_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLAYERS; i++) begin
        mtx_r[i] <= '0;
      end
      sel_r  <= SEL_BOTH;
      line_r <= LINES_IDLE;
      irq_r  <= 1'b0;
      acc_r  <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < PLAYERS; i++) begin
        mtx_r[i] <= mtx_nxt[i];
      end
      sel_r  <= sel_nxt;
      line_r <= line_nxt;
      irq_r  <= irq_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Read value as it stands after the item.
  assign res.joyp_value = {JOYP_TOP, sel_nxt, line_nxt};
  assign res.irq        = irq_nxt;
  assign res.accessed   = acc_nxt;

  // An acknowledge always leaves the interrupt clear.
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.op == OP_ACK_IRQ) |=> !irq_r)
    else $error("interrupt still pending after acknowledge");

  // The interrupt is only ever raised together with the accessed flag.
  a_irq_sets_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> acc_r)
    else $error("interrupt raised without accessed flag");

  // Select bits move only on a select write.
  a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && (item.op == OP_WR_SEL)) |=> $stable(sel_r))
    else $error("select bits changed without a select write");

  // With updates disabled, key and select operations leave the lines alone.
  a_upd_dis: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.upd_dis && ((item.op == OP_WR_SEL) || (item.op == OP_SET_KEY) ||
    (item.op == OP_SET_MASK)) |=> $stable(line_r))
    else $error("lines recomputed while updates are disabled");

endmodule

// ----- src/handheld_joypad_matrix_register_core.sv -----
// ----------------------------------------------------------------------------
// handheld_joypad_matrix_register_core: joypad register with key matrix
// Top level: configuration registers, input register, state update and the
// output register of the read value and interrupt flags.
// ----------------------------------------------------------------------------
// The core accepts one transfer per clock cycle while the result stream does not
// stall, and returns exactly one result transfer for each, in order. Each item
// waits in the input register, from which the state update applies the whole
// operation in a single pass and loads the output register, which offers the
// result. Because every item leaves its state at the end of that pass, the
// next item sees it at once and no bubble is needed. The output register
// lets a new item be taken while a finished result still waits downstream.
// Configuration writes take effect at the next edge and belong to idle times.
module handheld_joypad_matrix_register_core
  import hjm_pkg::*;
#(
  parameter int PLAYERS = PLAYERS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // select_bits[1:0], player[3:2], key_index[6:4], pressed[7], key_mask[15:8],
  // clear_all_players[16], nibble_value[20:17], active_player[22:21], zero[23]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // joyp_value[7:0], interrupt_request[8], accessed[9], zero[15:10]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  advance;
  logic  item_vld;
  item_t item;
  logic  fire;
  res_t  res;
  res_t  res_r;
  logic  out_vld_r;
  logic  out_vld_nxt;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_UPD_DIS: cfg_nxt.upd_dis = cfg_data[0];
        CFG_SGB:     cfg_nxt.sgb     = cfg_data[0];
        CFG_PCOUNT:  cfg_nxt.pcount  = cfg_data;
        CFG_OPPOSE:  cfg_nxt.oppose  = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upd_dis <= 1'b0;
      cfg_r.sgb     <= 1'b0;
      cfg_r.pcount  <= 3'd1;
      cfg_r.oppose  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The output register can load when empty or being emptied.
  assign advance = !out_vld_r || out_tready;
  assign fire    = item_vld && advance;

  hjm_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  hjm_engine #(
    .PLAYERS (PLAYERS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  // Output register.
  always_comb begin
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b000000, res_r.accessed, res_r.irq, res_r.joyp_value};

endmodule
